### sv/sis_pkg.sv
`default_nettype none
package sis_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int FILL_W     = $clog2(DEPTH + 1);

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 16;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int WHERE_W  = 6;
  localparam int RDATA_W  = 16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic   ins_go;
    logic   del_go;
    value_t value;
  } cell_cmd_t;

  typedef struct packed {
    logic lt;
    logic ge;
    logic eq;
  } cell_flags_t;

endpackage
`default_nettype wire

### sv/sis_cell.sv
`default_nettype none
module sis_cell (
  input  logic                clk_i,
  input  sis_pkg::cell_cmd_t  cmd_i,
  input  logic                occ_i,
  input  logic                prev_lt_i,
  input  sis_pkg::value_t     prev_value_i,
  input  sis_pkg::value_t     next_value_i,
  output sis_pkg::value_t     value_o,
  output sis_pkg::cell_flags_t flags_o
);
  import sis_pkg::*;

  value_t value_q;
  value_t value_d;

  assign flags_o.lt = occ_i & (value_q < cmd_i.value);
  assign flags_o.ge = occ_i & (value_q >= cmd_i.value);
  assign flags_o.eq = occ_i & (value_q == cmd_i.value);

  // An insert keeps smaller entries, drops the new value into the first
  // cell that is not smaller, and shifts every later cell up by one.
  // A delete pulls every cell at or above the removed value down by one.
  always_comb begin
    value_d = value_q;
    if (cmd_i.ins_go) begin
      if (!flags_o.lt) begin
        value_d = prev_lt_i ? cmd_i.value : prev_value_i;
      end
    end else if (cmd_i.del_go && flags_o.ge) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

### sv/sorted_index_set_top.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o  | mode_i, value_i, position_i
// out     | output    | out_valid_o / out_ready_i| status_o, count_o, where_o, read_value_o
//
// One beat is taken per cycle while no result is stalled; its result appears in
// the output register on the next cycle. The row of compare-and-shift cells
// settles an insert, delete or read combinationally in the cycle of acceptance.
// Reset clears the fill count and the output valid; entry cells hold no reset.
// While a result waits with out_ready_i low, in_ready_o is low.
`default_nettype none
module sorted_index_set_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sis_pkg::MODE_W-1:0]         mode_i,
  input  logic [sis_pkg::VALUE_W-1:0]        value_i,
  input  logic [sis_pkg::POS_W-1:0]          position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sis_pkg::STATUS_W-1:0]       status_o,
  output logic [sis_pkg::COUNT_W-1:0]        count_o,
  output logic [sis_pkg::WHERE_W-1:0]        where_o,
  output logic [sis_pkg::RDATA_W-1:0]        read_value_o
);
  import sis_pkg::*;

  logic [FILL_W-1:0]   fill_q, fill_d;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [COUNT_W-1:0]  count_q;
  logic [WHERE_W-1:0]  where_q, where_d;
  logic [RDATA_W-1:0]  rdata_q, rdata_d;

  logic        accept;
  cell_cmd_t   cmd;
  value_t      in_value;
  value_t      cell_value [DEPTH];
  cell_flags_t cell_flags [DEPTH];
  logic        prev_lt    [DEPTH];
  value_t      prev_value [DEPTH];
  value_t      next_value [DEPTH];
  logic        occ        [DEPTH];

  logic             found;
  logic             full;
  logic [IDX_W-1:0] slot_idx;
  logic [IDX_W-1:0] match_idx;
  value_t           rd_value;
  logic             pos_ok;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_value   = value_i[VALUE_BITS-1:0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign occ[g] = fill_q > FILL_W'(g);
    if (g == 0) begin : g_first
      assign prev_lt[g]    = 1'b1;
      assign prev_value[g] = '0;
    end else begin : g_rest
      assign prev_lt[g]    = cell_flags[g-1].lt;
      assign prev_value[g] = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_value[g] = '0;
    end else begin : g_mid
      assign next_value[g] = cell_value[g+1];
    end

    sis_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[g]),
      .prev_lt_i    (prev_lt[g]),
      .prev_value_i (prev_value[g]),
      .next_value_i (next_value[g]),
      .value_o      (cell_value[g]),
      .flags_o      (cell_flags[g])
    );
  end

  always_comb begin
    found     = 1'b0;
    slot_idx  = '0;
    match_idx = '0;
    rd_value  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found = found | cell_flags[i].eq;
      if (prev_lt[i] && !cell_flags[i].lt) begin
        slot_idx = slot_idx | IDX_W'(i);
      end
      if (cell_flags[i].eq) begin
        match_idx = match_idx | IDX_W'(i);
      end
      if (int'(position_i) == i) begin
        rd_value = rd_value | cell_value[i];
      end
    end
  end

  assign full   = fill_q == FILL_W'(DEPTH);
  assign pos_ok = (int'(position_i) < int'(fill_q)) && (int'(position_i) < DEPTH);

  assign cmd.value  = in_value;
  assign cmd.ins_go = accept && (mode_i == MODE_INSERT) && !found && !full;
  assign cmd.del_go = accept && (mode_i == MODE_DELETE) && found;

  always_comb begin
    fill_d   = fill_q;
    status_d = ST_OK;
    where_d  = '0;
    rdata_d  = '0;
    case (mode_i)
      MODE_INSERT: begin
        if (found) begin
          status_d = ST_DUPLICATE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          where_d = WHERE_W'(slot_idx);
          fill_d  = fill_q + FILL_W'(1);
        end
      end
      MODE_DELETE: begin
        if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          where_d = WHERE_W'(match_idx);
          fill_d  = fill_q - FILL_W'(1);
        end
      end
      MODE_READ: begin
        if (!pos_ok) begin
          status_d = ST_RANGE;
        end else begin
          where_d = WHERE_W'(position_i);
          rdata_d = RDATA_W'(rd_value);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      count_q  <= COUNT_W'(fill_d);
      where_q  <= where_d;
      rdata_q  <= rdata_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign count_o      = count_q;
  assign where_o      = where_q;
  assign read_value_o = rdata_q;

endmodule
`default_nettype wire

### sv/sis_checker.sv
`default_nettype none
module sis_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [sis_pkg::STATUS_W-1:0]  status_o,
  input logic [sis_pkg::COUNT_W-1:0]   count_o,
  input logic [sis_pkg::WHERE_W-1:0]   where_o,
  input logic [sis_pkg::RDATA_W-1:0]   read_value_o
);
  import sis_pkg::*;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(count_o)
      && $stable(where_o) && $stable(read_value_o))
    else $error("Stalled result beat changed.");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("Input taken while a result beat is stalled.");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> where_o == '0 && read_value_o == '0)
    else $error("Rejected beat carries a position or value.");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == COUNT_W'(DEPTH))
    else $error("Full status with a count below capacity.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(count_o) <= DEPTH)
    else $error("Count exceeds capacity.");

endmodule

bind sorted_index_set_top sis_checker u_sis_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .count_o      (count_o),
  .where_o      (where_o),
  .read_value_o (read_value_o)
);
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sis_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int N_STEPS = 25;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [WHERE_W-1:0]  where;
    logic [RDATA_W-1:0]  rdata;
  } reply_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic               typed;
    reply_t             reply;
  } step_t;

  // Rows with typed set carry a hand-written result; the rest use the set model.
  localparam step_t STEPS [N_STEPS] = '{
    '{MODE_READ,   16'h0000, 6'd0,  1'b1, '{ST_RANGE,     7'd0, 6'd0, 16'h0000}},
    '{MODE_DELETE, 16'h1234, 6'd0,  1'b1, '{ST_NOT_FOUND, 7'd0, 6'd0, 16'h0000}},
    '{MODE_SPARE,  16'hFFFF, 6'd63, 1'b1, '{ST_OK,        7'd0, 6'd0, 16'h0000}},
    '{MODE_INSERT, 16'hFFFF, 6'd0,  1'b1, '{ST_OK,        7'd1, 6'd0, 16'h0000}},
    '{MODE_INSERT, 16'h0000, 6'd63, 1'b1, '{ST_OK,        7'd2, 6'd0, 16'h0000}},
    '{MODE_INSERT, 16'h8000, 6'd0,  1'b1, '{ST_OK,        7'd3, 6'd1, 16'h0000}},
    '{MODE_INSERT, 16'h7FFF, 6'd0,  1'b1, '{ST_OK,        7'd4, 6'd1, 16'h0000}},
    '{MODE_INSERT, 16'h0000, 6'd0,  1'b1, '{ST_DUPLICATE, 7'd4, 6'd0, 16'h0000}},
    '{MODE_INSERT, 16'h8000, 6'd0,  1'b1, '{ST_DUPLICATE, 7'd4, 6'd0, 16'h0000}},
    '{MODE_INSERT, 16'hFFFF, 6'd0,  1'b1, '{ST_DUPLICATE, 7'd4, 6'd0, 16'h0000}},
    '{MODE_READ,   16'h0000, 6'd0,  1'b1, '{ST_OK,        7'd4, 6'd0, 16'h0000}},
    '{MODE_READ,   16'h0000, 6'd3,  1'b1, '{ST_OK,        7'd4, 6'd3, 16'hFFFF}},
    '{MODE_READ,   16'h0000, 6'd4,  1'b1, '{ST_RANGE,     7'd4, 6'd0, 16'h0000}},
    '{MODE_READ,   16'hFFFF, 6'd63, 1'b1, '{ST_RANGE,     7'd4, 6'd0, 16'h0000}},
    '{MODE_DELETE, 16'h7FFF, 6'd0,  1'b1, '{ST_OK,        7'd3, 6'd1, 16'h0000}},
    '{MODE_DELETE, 16'h7FFF, 6'd0,  1'b1, '{ST_NOT_FOUND, 7'd3, 6'd0, 16'h0000}},
    '{MODE_READ,   16'h0000, 6'd1,  1'b0, '0},
    '{MODE_INSERT, 16'h5555, 6'd0,  1'b0, '0},
    '{MODE_DELETE, 16'hFFFF, 6'd0,  1'b1, '{ST_OK,        7'd3, 6'd3, 16'h0000}},
    '{MODE_DELETE, 16'h0000, 6'd0,  1'b1, '{ST_OK,        7'd2, 6'd0, 16'h0000}},
    '{MODE_READ,   16'h0000, 6'd1,  1'b0, '0},
    '{MODE_SPARE,  16'h0000, 6'd0,  1'b1, '{ST_OK,        7'd2, 6'd0, 16'h0000}},
    '{MODE_DELETE, 16'h5555, 6'd0,  1'b1, '{ST_OK,        7'd1, 6'd0, 16'h0000}},
    '{MODE_DELETE, 16'h8000, 6'd0,  1'b1, '{ST_OK,        7'd0, 6'd0, 16'h0000}},
    '{MODE_READ,   16'h0000, 6'd0,  1'b1, '{ST_RANGE,     7'd0, 6'd0, 16'h0000}}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [MODE_W-1:0]   mode_i;
  logic [VALUE_W-1:0]  value_i;
  logic [POS_W-1:0]    position_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  count_o;
  logic [WHERE_W-1:0]  where_o;
  logic [RDATA_W-1:0]  read_value_o;

  value_t held [DEPTH];
  int     held_n;
  bit     growing;
  int     idle_pct;
  int     stall_pct;
  int     hold_left;
  int     bad_beats;
  reply_t pending_results [$];
  reply_t oldest;

  sorted_index_set_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .count_o     (count_o),
    .where_o     (where_o),
    .read_value_o(read_value_o)
  );

  function automatic reply_t sorted_set_step(logic [MODE_W-1:0] m, value_t v,
                                             logic [POS_W-1:0] p);
    reply_t r;
    int     slot;
    int     hit;
    r = '0;
    case (m)
      MODE_INSERT: begin
        slot = 0;
        hit  = -1;
        for (int i = 0; i < held_n; i++) begin
          if (held[i] == v) hit = i;
          if (held[i] < v) slot = i + 1;
        end
        if (hit >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (held_n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = held_n; i > slot; i--) held[i] = held[i-1];
          held[slot] = v;
          held_n++;
          r.status = ST_OK;
          r.where  = WHERE_W'(slot);
        end
      end
      MODE_DELETE: begin
        hit = -1;
        for (int i = 0; i < held_n; i++) begin
          if (hit < 0 && held[i] == v) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < held_n; i++) held[i] = held[i+1];
          held_n--;
          r.status = ST_OK;
          r.where  = WHERE_W'(hit);
        end
      end
      MODE_READ: begin
        if (int'(p) >= held_n) begin
          r.status = ST_RANGE;
        end else begin
          r.status = ST_OK;
          r.where  = p;
          r.rdata  = held[p];
        end
      end
      default: r.status = ST_OK;
    endcase
    r.count = COUNT_W'(held_n);
    return r;
  endfunction

  task automatic queue_result(input reply_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic offer(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v,
                       input logic [POS_W-1:0] p, input logic typed, input reply_t want);
    reply_t pred;
    logic   took;
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_i    <= v;
    position_i <= p;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end
    pred = sorted_set_step(m, v, p);
    queue_result(typed ? want : pred);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_items(input int n);
    int                 done;
    int                 roll;
    logic [MODE_W-1:0]  m;
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0]   p;
    done = 0;
    while (done < n) begin
      roll = $urandom_range(99);
      if (growing ? roll < 65 : roll < 12) m = MODE_INSERT;
      else if (growing ? roll < 77 : roll < 75) m = MODE_DELETE;
      else if (roll < 96) m = MODE_READ;
      else m = MODE_SPARE;
      roll = $urandom_range(99);
      if (held_n > 0 && roll < (m == MODE_DELETE ? 70 : 15))
        v = held[$urandom_range(held_n - 1)];
      else if (roll < 80)
        v = $urandom_range(1) ? VALUE_W'($urandom_range(15)) :
                                16'hFFFF - VALUE_W'($urandom_range(15));
      else
        v = VALUE_W'($urandom);
      if (m == MODE_READ && held_n > 0 && $urandom_range(3) != 0)
        p = POS_W'($urandom_range(held_n - 1));
      else
        p = POS_W'($urandom_range(63));
      offer(m, v, p, 1'b0, '0);
      if (m != MODE_SPARE) done++;
      if (growing && held_n == DEPTH && $urandom_range(5) == 0) growing = 1'b0;
      else if (!growing && held_n == 0) growing = 1'b1;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d count=%0d where=%0d data=%h",
                 $time, status_o, count_o, where_o, read_value_o);
        bad_beats++;
      end else begin
        oldest = pending_results.pop_front();
        if (status_o !== oldest.status || count_o !== oldest.count ||
            where_o !== oldest.where || read_value_o !== oldest.rdata) begin
          $display("%0t: expected status=%0d count=%0d where=%0d data=%h",
                   $time, oldest.status, oldest.count, oldest.where, oldest.rdata);
          $display("%0t: actual   status=%0d count=%0d where=%0d data=%h",
                   $time, status_o, count_o, where_o, read_value_o);
          bad_beats++;
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    mode_i     = '0;
    value_i    = '0;
    position_i = '0;
    held_n     = 0;
    growing    = 1'b1;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_left  = 0;
    bad_beats  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < N_STEPS; k++) begin
      offer(STEPS[k].mode, STEPS[k].value, STEPS[k].pos, STEPS[k].typed, STEPS[k].reply);
    end
    drain_results();

    // The output is held off while beats keep coming, so the input must stall.
    random_items(100);
    hold_left = 150;
    random_items(200);
    drain_results();

    idle_pct  = 60;
    stall_pct = 0;
    random_items(300);
    drain_results();

    idle_pct  = 0;
    stall_pct = 60;
    random_items(300);
    drain_results();

    idle_pct  = 30;
    stall_pct = 30;
    random_items(300);
    drain_results();

    repeat (5) @(posedge clk_i);
    if (bad_beats == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
